### rtl/udp_socket_demux_table_top_assert.svh
`ifndef UDP_SOCKET_DEMUX_TABLE_TOP_ASSERT_SVH
`define UDP_SOCKET_DEMUX_TABLE_TOP_ASSERT_SVH

// checked on every edge outside reset
`define UDT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("udt assertion failed");

// checked on every edge, reset included
`define UDT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("udt assertion failed");

`endif

### rtl/udt_pkg.sv
`timescale 1ns / 1ps

package udt_pkg;

   localparam int DEFAULT_ENTRIES = 16;

   localparam logic [2:0] CMD_CREATE = 3'd0;
   localparam logic [2:0] CMD_CLOSE  = 3'd1;
   localparam logic [2:0] CMD_BIND   = 3'd2;
   localparam logic [2:0] CMD_REMOTE = 3'd3;
   localparam logic [2:0] CMD_LOOKUP = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOMATCH  = 3'd1;
   localparam logic [2:0] ST_INUSE    = 3'd2;
   localparam logic [2:0] ST_BOUND    = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_NOHANDLE = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  handle;
      logic [31:0] local_addr;
      logic [15:0] local_port_in;
      logic [31:0] remote_addr;
      logic [15:0] remote_port_in;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] hit_handle;
      logic       weak_hit;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  handle;
      logic [31:0] local_addr;
      logic [15:0] lcl_port;
      logic [31:0] remote_addr;
      logic [15:0] rmt_port;
   } entry_type;

   typedef struct packed {
      logic        active;
      req_type     req;
      logic        pass2;
      logic        found;
      logic        bound;
      logic        inuse;
      logic        hit_strong;
      logic        hit_weak;
      logic [3:0]  hit;
   } token_type;

endpackage

### rtl/udp_socket_demux_table_top.sv
`timescale 1ns / 1ps
// one transaction at a time travels the row of entry cells, one cell per cycle
// a transaction passes the head register, then each cell, then the pend and the
// response registers; a bind that passes its checks walks the row twice
// a new transaction is taken only after the last result leaves the pend register,
// so the next is taken while a result waits at the output; the row length sets the time
// synchronous reset clears every entry valid bit and all handshake state

module udp_socket_demux_table_top #(
   parameter int ENTRIES = udt_pkg::DEFAULT_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  udt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output udt_pkg::rsp_type rsp_data
);
   import udt_pkg::*;

   token_type head_ff, head_in;
   logic      busy_ff, busy_in;
   rsp_type   pend_ff, pend_in;
   logic      pend_valid_ff, pend_valid_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   token_type tok_w [ENTRIES];
   entry_type ent_w [ENTRIES];
   token_type tail;
   logic      accept;
   logic      reinject;
   logic      move;
   rsp_type   result;

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         token_type up_w;
         entry_type nbr_w;
         if (gi == 0) begin : g_first
            assign up_w = head_ff;
         end else begin : g_mid
            assign up_w = tok_w[gi-1];
         end
         if (gi == ENTRIES - 1) begin : g_last
            assign nbr_w = '0;
         end else begin : g_next
            assign nbr_w = ent_w[gi+1];
         end
         udt_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .up_tok    (up_w),
            .nbr_entry (nbr_w),
            .entry_out (ent_w[gi]),
            .tok_out   (tok_w[gi])
         );
      end
   endgenerate

   assign tail      = tok_w[ENTRIES-1];
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign move      = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      result = '0;
      case (tail.req.cmd)
         CMD_CREATE: result.status = tail.found ? ST_OK : ST_FULL;
         CMD_CLOSE,
         CMD_REMOTE: result.status = tail.found ? ST_OK : ST_NOHANDLE;
         CMD_BIND: begin
            if (!tail.found) begin
               result.status = ST_NOHANDLE;
            end else if (tail.pass2) begin
               result.status = ST_OK;
            end else if (tail.bound) begin
               result.status = ST_BOUND;
            end else if (tail.inuse) begin
               result.status = ST_INUSE;
            end else begin
               result.status = ST_OK;
            end
         end
         CMD_LOOKUP: begin
            if (tail.hit_strong) begin
               result.hit_handle = tail.hit;
            end else if (tail.hit_weak) begin
               result.hit_handle = tail.hit;
               result.weak_hit   = 1'b1;
            end else begin
               result.status = ST_NOMATCH;
            end
         end
         default: result.status = ST_OK;
      endcase
   end

   always_comb begin
      reinject = tail.active && (tail.req.cmd == CMD_BIND) && !tail.pass2 &&
                 tail.found && !tail.bound && !tail.inuse;
      head_in        = head_ff;
      head_in.active = 1'b0;
      if (accept) begin
         head_in        = '0;
         head_in.active = 1'b1;
         head_in.req    = req_data;
      end else if (reinject) begin
         head_in       = tail;
         head_in.pass2 = 1'b1;
         head_in.found = 1'b0;
      end

      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff && !move;
      if (tail.active && !reinject) begin
         pend_in       = result;
         pend_valid_in = 1'b1;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (move) begin
         rsp_in       = pend_ff;
         rsp_valid_in = 1'b1;
      end

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.active <= 1'b0;
         busy_ff        <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_ff       <= head_in;
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/udt_cell.sv
`timescale 1ns / 1ps

module udt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  udt_pkg::token_type    up_tok,
   input  udt_pkg::entry_type    nbr_entry,
   output udt_pkg::entry_type    entry_out,
   output udt_pkg::token_type    tok_out
);
   import udt_pkg::*;

   entry_type entry_ff, entry_in;
   token_type tok_ff, tok_in;

   logic here;
   logic port_eq;
   logic laddr_ok;
   logic raddr_ok;
   logic rport_ok;

   always_comb begin
      entry_in = entry_ff;
      tok_in   = up_tok;
      here     = entry_ff.valid && (entry_ff.handle == up_tok.req.handle) && !up_tok.found;
      port_eq  = entry_ff.valid && (entry_ff.lcl_port == up_tok.req.local_port_in);
      laddr_ok = (entry_ff.local_addr == 32'd0) ||
                 (entry_ff.local_addr == up_tok.req.local_addr);
      raddr_ok = (entry_ff.remote_addr == 32'd0) ||
                 (entry_ff.remote_addr == up_tok.req.remote_addr);
      rport_ok = (entry_ff.rmt_port == 16'd0) ||
                 (entry_ff.rmt_port == up_tok.req.remote_port_in);
      if (up_tok.active) begin
         case (up_tok.req.cmd)
            CMD_CREATE: begin
               if (!up_tok.found && !entry_ff.valid) begin
                  entry_in.valid       = 1'b1;
                  entry_in.handle      = up_tok.req.handle;
                  entry_in.local_addr  = 32'd0;
                  entry_in.lcl_port    = 16'd0;
                  entry_in.remote_addr = 32'd0;
                  entry_in.rmt_port    = 16'd0;
                  tok_in.found         = 1'b1;
               end
            end
            CMD_CLOSE: begin
               if (here || up_tok.found) begin
                  entry_in     = nbr_entry;
                  tok_in.found = 1'b1;
               end
            end
            CMD_BIND: begin
               if (here) begin
                  tok_in.found = 1'b1;
                  if (up_tok.pass2) begin
                     entry_in.local_addr = up_tok.req.local_addr;
                     entry_in.lcl_port   = up_tok.req.local_port_in;
                  end else begin
                     tok_in.bound = (entry_ff.lcl_port != 16'd0);
                  end
               end else if (!up_tok.pass2 && port_eq) begin
                  tok_in.inuse = 1'b1;
               end
            end
            CMD_REMOTE: begin
               if (here) begin
                  entry_in.remote_addr = up_tok.req.remote_addr;
                  entry_in.rmt_port    = up_tok.req.remote_port_in;
                  tok_in.found         = 1'b1;
               end
            end
            CMD_LOOKUP: begin
               if (!up_tok.hit_strong && port_eq && laddr_ok && rport_ok) begin
                  if (raddr_ok) begin
                     tok_in.hit_strong = 1'b1;
                     tok_in.hit        = entry_ff.handle;
                  end else if (!up_tok.hit_weak) begin
                     tok_in.hit_weak = 1'b1;
                     tok_in.hit      = entry_ff.handle;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         tok_ff.active  <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         tok_ff   <= tok_in;
      end
   end

   assign entry_out = entry_ff;
   assign tok_out   = tok_ff;

endmodule

### rtl/udt_checker.sv
`timescale 1ns / 1ps
`include "udp_socket_demux_table_top_assert.svh"

module udt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input udt_pkg::rsp_type rsp_data
);
   import udt_pkg::*;

   logic rsp_dirty;
   assign rsp_dirty = (rsp_data.hit_handle != 4'd0) || rsp_data.weak_hit;

   `UDT_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid && req_ready)
   `UDT_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready)
   `UDT_ASSERT(a_miss_clean, rsp_valid && (rsp_data.status != ST_OK) |-> !rsp_dirty)
   `UDT_ASSERT(a_status_code, rsp_valid |-> (rsp_data.status <= ST_NOHANDLE))
   `UDT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

endmodule

bind udp_socket_demux_table_top udt_checker u_udt_checker (.*);

### tb/tb_udp_socket_demux_table_top.sv
`timescale 1ns / 1ps

module tb_udp_socket_demux_table_top;
   import udt_pkg::*;

   localparam int ENTRIES = udt_pkg::DEFAULT_ENTRIES;
   localparam int RANDOM_COMMANDS = 750;
   localparam int HOLD_START = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int CALM_START = 12000;
   localparam int CALM_STOP = 20000;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   class demux_scoreboard;
      entry_type tbl[ENTRIES];
      rsp_type pending_answers[$];
      int errors;

      function new();
         foreach (tbl[i]) tbl[i] = '0;
         errors = 0;
      endfunction

      function int occupancy();
         int n;
         n = 0;
         foreach (tbl[i]) if (tbl[i].valid) n++;
         return n;
      endfunction

      function int oldest_slot(logic [3:0] h);
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl[i].valid && tbl[i].handle == h) return i;
         end
         return -1;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      // applies one command to the socket table and returns its answer
      function rsp_type demux_outcome(req_type r);
         rsp_type a;
         int p;
         int n;
         int strong_at;
         int weak_at;
         bit addr_ok;
         bit port_ok;
         a = '0;
         a.status = ST_OK;
         case (r.cmd)
            CMD_CREATE: begin
               n = occupancy();
               if (n >= ENTRIES) begin
                  a.status = ST_FULL;
               end else begin
                  tbl[n] = '0;
                  tbl[n].valid = 1'b1;
                  tbl[n].handle = r.handle;
               end
            end
            CMD_CLOSE: begin
               p = oldest_slot(r.handle);
               if (p < 0) begin
                  a.status = ST_NOHANDLE;
               end else begin
                  for (int i = p; i + 1 < ENTRIES; i++) tbl[i] = tbl[i + 1];
                  tbl[ENTRIES - 1].valid = 1'b0;
               end
            end
            CMD_BIND: begin
               p = oldest_slot(r.handle);
               if (p < 0) begin
                  a.status = ST_NOHANDLE;
               end else if (tbl[p].lcl_port != 16'd0) begin
                  a.status = ST_BOUND;
               end else begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (i != p && tbl[i].valid && tbl[i].lcl_port == r.local_port_in)
                        a.status = ST_INUSE;
                  end
                  if (a.status == ST_OK) begin
                     tbl[p].local_addr = r.local_addr;
                     tbl[p].lcl_port = r.local_port_in;
                  end
               end
            end
            CMD_REMOTE: begin
               p = oldest_slot(r.handle);
               if (p < 0) begin
                  a.status = ST_NOHANDLE;
               end else begin
                  tbl[p].remote_addr = r.remote_addr;
                  tbl[p].rmt_port = r.remote_port_in;
               end
            end
            CMD_LOOKUP: begin
               strong_at = -1;
               weak_at = -1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (tbl[i].valid && tbl[i].lcl_port == r.local_port_in &&
                      (tbl[i].local_addr == 32'd0 || tbl[i].local_addr == r.local_addr)) begin
                     addr_ok = tbl[i].remote_addr == 32'd0 ||
                               tbl[i].remote_addr == r.remote_addr;
                     port_ok = tbl[i].rmt_port == 16'd0 ||
                               tbl[i].rmt_port == r.remote_port_in;
                     if (addr_ok && port_ok) begin
                        strong_at = i;
                        break;
                     end
                     if (!addr_ok && port_ok && weak_at < 0) weak_at = i;
                  end
               end
               if (strong_at >= 0) begin
                  a.hit_handle = tbl[strong_at].handle;
               end else if (weak_at >= 0) begin
                  a.hit_handle = tbl[weak_at].handle;
                  a.weak_hit = 1'b1;
               end else begin
                  a.status = ST_NOMATCH;
               end
            end
            default: ;
         endcase
         return a;
      endfunction

      function void accept_command(req_type r);
         pending_answers.push_back(demux_outcome(r));
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (pending_answers.size() == 0) begin
            flag($sformatf("unexpected answer: status %0d handle %0d weak %0d",
                           got.status, got.hit_handle, got.weak_hit));
            return;
         end
         want = pending_answers.pop_front();
         if (got.status !== want.status || got.hit_handle !== want.hit_handle ||
             got.weak_hit !== want.weak_hit)
            flag($sformatf("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           want.status, want.hit_handle, want.weak_hit,
                           got.status, got.hit_handle, got.weak_hit));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   demux_scoreboard sb = new();
   logic [31:0] addr_pool[4];
   logic [15:0] port_pool[6];
   bit sender_calm;

   udp_socket_demux_table_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_udp_socket_demux_table_top: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_answer(rsp_data);
         if (req_valid && req_ready) sb.accept_command(req_data);
      end
   end

   // receiver: random stalls, one long hold-off, one stretch always ready
   initial begin
      int cycle;
      rsp_ready = 1'b0;
      cycle = 0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else if (cycle >= CALM_START && cycle < CALM_STOP)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= 9);
      end
   end

   function automatic req_type command_of(logic [2:0] cmd, logic [3:0] h, logic [31:0] la,
                                          logic [15:0] lp, logic [31:0] ra, logic [15:0] rp);
      req_type r;
      r.cmd = cmd;
      r.handle = h;
      r.local_addr = la;
      r.local_port_in = lp;
      r.remote_addr = ra;
      r.remote_port_in = rp;
      return r;
   endfunction

   function automatic logic [31:0] pick_addr();
      int sel;
      sel = $urandom_range(9);
      if (sel < 2) return 32'd0;
      if (sel < 7) return addr_pool[$urandom_range(3)];
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_port();
      int sel;
      sel = $urandom_range(9);
      if (sel < 1) return 16'd0;
      if (sel < 7) return port_pool[$urandom_range(5)];
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic [3:0] pick_handle(int n);
      if (n > 0 && $urandom_range(9) < 8) return sb.tbl[$urandom_range(n - 1)].handle;
      return 4'($urandom_range(15));
   endfunction

   // mostly commands aimed at live sockets, with lookups built from their bindings
   function automatic req_type random_command();
      req_type r;
      entry_type e;
      int n;
      int sel;
      n = sb.occupancy();
      r = command_of(CMD_CREATE, 4'($urandom_range(15)), pick_addr(), pick_port(),
                     pick_addr(), pick_port());
      sel = $urandom_range(99);
      if (sel < 13) begin
         r.cmd = CMD_CREATE;
      end else if (sel < 24) begin
         r.cmd = CMD_CLOSE;
         r.handle = pick_handle(n);
      end else if (sel < 42) begin
         r.cmd = CMD_BIND;
         r.handle = pick_handle(n);
      end else if (sel < 56) begin
         r.cmd = CMD_REMOTE;
         r.handle = pick_handle(n);
      end else if (sel < 97) begin
         r.cmd = CMD_LOOKUP;
         if (n > 0 && $urandom_range(9) < 7) begin
            e = sb.tbl[$urandom_range(n - 1)];
            r.local_port_in = e.lcl_port;
            if (e.local_addr != 32'd0 && $urandom_range(9) != 0) r.local_addr = e.local_addr;
            if (e.rmt_port != 16'd0 && $urandom_range(3) != 0)
               r.remote_port_in = e.rmt_port;
            if (e.remote_addr != 32'd0 && $urandom_range(2) != 0)
               r.remote_addr = e.remote_addr;
         end
      end else begin
         r.cmd = 3'($urandom_range(5, 7));
      end
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_command(req_type r);
      if (!sender_calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending_answers.size() != 0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sender_calm = 1'b0;
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      foreach (port_pool[i]) port_pool[i] = 16'($urandom_range(1, 65535));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table and unknown handles
      send_command(command_of(CMD_LOOKUP, 4'd0, '1, 16'hFFFF, '1, 16'hFFFF));
      send_command(command_of(CMD_CLOSE, 4'd15, '0, '0, '0, '0));
      send_command(command_of(CMD_REMOTE, 4'd15, '0, '0, '1, '1));
      // fill the table, with a duplicate handle, then overflow
      for (int i = 0; i < ENTRIES - 1; i++)
         send_command(command_of(CMD_CREATE, i[3:0], '0, '0, '0, '0));
      send_command(command_of(CMD_CREATE, 4'd0, '0, '0, '0, '0));
      send_command(command_of(CMD_CREATE, 4'd7, '1, '1, '1, '1));
      // port zero clashes with the unbound sockets
      send_command(command_of(CMD_BIND, 4'd0, 32'h0A00_0001, 16'd0, '0, '0));
      send_command(command_of(CMD_BIND, 4'd15, '1, 16'hFFFF, '0, '0));
      send_command(command_of(CMD_BIND, 4'd0, 32'd0, 16'hFFFF, '0, '0));
      send_command(command_of(CMD_BIND, 4'd0, '1, 16'd1, '0, '0));
      send_command(command_of(CMD_BIND, 4'd1, '1, 16'hFFFF, '0, '0));
      send_command(command_of(CMD_REMOTE, 4'd0, '0, '0, 32'hC0A8_0001, 16'hFFFF));
      // strong, weak and missed lookups
      send_command(command_of(CMD_LOOKUP, 4'd0, '1, 16'hFFFF, 32'hC0A8_0001, 16'hFFFF));
      send_command(command_of(CMD_LOOKUP, 4'd0, '1, 16'hFFFF, 32'h0A00_0002, 16'hFFFF));
      send_command(command_of(CMD_LOOKUP, 4'd0, '0, 16'hFFFF, 32'hC0A8_0001, 16'd1));
      // close removes the oldest of the two sockets with handle 0
      send_command(command_of(CMD_CLOSE, 4'd0, '0, '0, '0, '0));
      send_command(command_of(CMD_LOOKUP, 4'd0, '1, 16'hFFFF, '0, '0));
      send_command(command_of(CMD_UNUSED, 4'd15, '1, 16'hFFFF, '1, 16'hFFFF));
      wait_for_answers();

      for (int k = 0; k < RANDOM_COMMANDS; k++) begin
         sender_calm = (k >= 200 && k < 320);
         if (k == RANDOM_COMMANDS / 2) wait_for_answers();
         send_command(random_command());
      end

      wait_for_answers();
      repeat (2 * ENTRIES + 8) @(negedge clock);
      if (sb.errors == 0 && sb.pending_answers.size() == 0)
         $display("tb_udp_socket_demux_table_top: PASS");
      else
         $display("tb_udp_socket_demux_table_top: FAIL");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/udt_pkg.sv
rtl/udt_cell.sv
rtl/udp_socket_demux_table_top.sv
rtl/udt_checker.sv
tb/tb_udp_socket_demux_table_top.sv
